/* design/wbss_pkg.sv */
// Package for the wildcard byte signature search block.
// Holds sizes, item structs, register codes and the per-cell reference type.
// No dependencies.
package wbss_pkg;

  // Window depth and position counter width
  localparam int SIG_BYTES     = 16;
  localparam int POSITION_BITS = 16;

  // Signature register file: two 64-bit words, 16 bytes
  localparam int REG_BYTES  = 16;
  localparam int REG_IDX_W  = $clog2(REG_BYTES);
  localparam int LEN_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int OFFSET_W   = 16;
  localparam int SUM_W      = (POSITION_BITS > OFFSET_W) ? POSITION_BITS : OFFSET_W;

  localparam logic [7:0] WILDCARD_BYTE = 8'hCC;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIG_LOW  = 2'd0,
    REG_SIG_HIGH = 2'd1,
    REG_SIG_LEN  = 2'd2
  } cfg_reg_e;

  // Input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] match_offset;
  } out_item_t;

  // What one window cell compares against
  typedef struct packed {
    logic       care;
    logic [7:0] sig;
  } cell_ref_t;

endpackage

/* design/wbss_cfg.sv */
// Configuration registers of the signature search.
// Aligns signature bytes to window cells for the current length.
// Depends on wbss_pkg.
module wbss_cfg (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          cfg_valid_i,
  output logic                                          cfg_ready_o,
  input  logic [wbss_pkg::CFG_IDX_W-1:0]                cfg_index_i,
  input  logic [wbss_pkg::CFG_DATA_W-1:0]               cfg_data_i,
  output wbss_pkg::cell_ref_t [wbss_pkg::SIG_BYTES-1:0] refs_o,
  output logic [wbss_pkg::LEN_W-1:0]                    eff_len_o
);
  import wbss_pkg::*;

  logic [CFG_DATA_W-1:0] sig_low_q, sig_high_q;
  logic [LEN_W-1:0]      sig_len_q;
  logic [LEN_W-1:0]      eff_len;
  logic [REG_BYTES-1:0][7:0] sig_bytes;

  assign cfg_ready_o = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_low_q  <= '0;
      sig_high_q <= '0;
      sig_len_q  <= LEN_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SIG_LOW:  sig_low_q  <= cfg_data_i;
        REG_SIG_HIGH: sig_high_q <= cfg_data_i;
        REG_SIG_LEN:  sig_len_q  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Length clamped to 1..SIG_BYTES
  always_comb begin
    eff_len = sig_len_q;
    if (sig_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (sig_len_q > LEN_W'(SIG_BYTES)) begin
      eff_len = LEN_W'(SIG_BYTES);
    end
  end

  assign eff_len_o = eff_len;
  assign sig_bytes = {sig_high_q, sig_low_q};

  // Cell j holds the byte that signature byte len-1-j must match
  for (genvar j = 0; j < SIG_BYTES; j++) begin : g_ref
    logic [LEN_W-1:0] k;
    logic [7:0]       s;
    assign k = eff_len - LEN_W'(1) - LEN_W'(j);
    assign s = sig_bytes[k[REG_IDX_W-1:0]];
    assign refs_o[j].sig  = s;
    assign refs_o[j].care = (LEN_W'(j) < eff_len) && (s != WILDCARD_BYTE);
  end

endmodule

/* design/wbss_cell.sv */
// One window cell: holds a byte, passes it to its neighbor on each shift,
// and flags whether its incoming byte fits its signature byte.
// Depends on wbss_pkg.
module wbss_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  logic [7:0]          byte_i,
  input  wbss_pkg::cell_ref_t ref_i,
  output logic [7:0]          byte_o,
  output logic                hit_o
);
  import wbss_pkg::*;

  logic [7:0] byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  // Compare on the value being shifted in
  assign hit_o  = !ref_i.care || (byte_i == ref_i.sig);
  assign byte_o = byte_q;

endmodule

/* design/wildcard_byte_signature_search.sv */
// Top level of the wildcard byte signature search.
// Depends on wbss_pkg, wbss_cfg and wbss_cell.
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_stall_o  | in_item_i  (in_item_t)
//   out     | output    | out_valid_o / out_stall_i| out_item_o (out_item_t)
//   cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One byte item per cycle while the input is not stalled; all cell compares run
// in the accept cycle and the result lands in the output register in the cycle after the item is taken.
// Input stalls only while a held result is itself stalled.
// Reset clears window, position, match flag and output valid; signature
// registers reset to zero with length one.
module wildcard_byte_signature_search (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  wbss_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output wbss_pkg::out_item_t              out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [wbss_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [wbss_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import wbss_pkg::*;

  cell_ref_t [SIG_BYTES-1:0] refs;
  logic [LEN_W-1:0]          eff_len;
  logic [SIG_BYTES-1:0][7:0] win;
  logic [SIG_BYTES-1:0]      hits;
  logic                      in_acc;

  logic [POSITION_BITS-1:0] pos_q, pos_d, pos_cur;
  logic                     rep_q, rep_d, rep_cur;
  logic                     match, emit;
  logic [SUM_W-1:0]         off_full;
  logic                     out_valid_q, out_valid_d;
  out_item_t                out_q;

  wbss_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .refs_o      (refs),
    .eff_len_o   (eff_len)
  );

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Window chain, newest byte in cell 0
  for (genvar j = 0; j < SIG_BYTES; j++) begin : g_cell
    logic [7:0] byte_in;
    if (j == 0) begin : g_head
      assign byte_in = in_item_i.data_byte;
    end else begin : g_body
      assign byte_in = win[j-1];
    end
    wbss_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_acc),
      .byte_i  (byte_in),
      .ref_i   (refs[j]),
      .byte_o  (win[j]),
      .hit_o   (hits[j])
    );
  end

  // Buffer tracking and result decision
  always_comb begin
    pos_cur  = in_item_i.first_byte ? '0 : pos_q;
    rep_cur  = in_item_i.first_byte ? 1'b0 : rep_q;
    match    = !rep_cur && (pos_cur != POS_MAX)
               && (pos_cur >= POSITION_BITS'(eff_len - LEN_W'(1))) && (&hits);
    emit     = match || (in_item_i.last_byte && !rep_cur);
    off_full = SUM_W'(pos_cur) + SUM_W'(1) - SUM_W'(eff_len);
    pos_d    = pos_q;
    rep_d    = rep_q;
    if (in_acc) begin
      if (in_item_i.last_byte) begin
        pos_d = '0;
        rep_d = 1'b0;
      end else begin
        pos_d = (pos_cur != POS_MAX) ? pos_cur + POSITION_BITS'(1) : pos_cur;
        rep_d = rep_cur || match;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      rep_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      rep_q <= rep_d;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (in_acc && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      out_q.found        <= match;
      out_q.match_offset <= match ? off_full[OFFSET_W-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Not-found results carry a zero offset
  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.found |-> out_item_o.match_offset == '0)
    else $error("not-found result with nonzero offset");

  // Input only stalls behind a held result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  // A buffer end clears the tracking state
  a_last_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_item_i.last_byte |=> pos_q == '0 && !rep_q)
    else $error("state not cleared after last byte");

  // A new result is only loaded by an accepted item
  a_load_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |=> !out_valid_o || $past(in_acc))
    else $error("result appeared without an accepted item");

endmodule

/* tb/sv/wildcard_byte_signature_search_test.sv */
// Self-checking testbench for wildcard_byte_signature_search.
// Depends on wbss_pkg and the block itself; predicts each search outcome
// from its own copy of the window, position and signature registers.
module wildcard_byte_signature_search_test;
  import wbss_pkg::*;

  // Pending byte item together with the idle gap drawn for it
  typedef struct {
    in_item_t    item;
    int unsigned gap;
  } feed_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_item_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  wildcard_byte_signature_search dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Byte feed, predicted outcomes and bookkeeping
  feed_t       byte_feed_q[$];
  out_item_t   search_outcomes_q[$];
  feed_t       feed_next;
  logic        byte_held = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned outcomes_seen = 0;
  int unsigned settings_used = 0;

  // Predictor copy of the registers and search state
  logic [63:0]            sig_lo_m = '0;
  logic [63:0]            sig_hi_m = '0;
  logic [LEN_W-1:0]       sig_len_m = LEN_W'(1);
  logic [7:0]             win_q[SIG_BYTES];
  logic [POSITION_BITS-1:0] buf_pos = '0;
  logic                   hit_seen = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Number of signature bytes in use; zero counts as one, clipped to the window
  function automatic int unsigned sig_span();
    int unsigned n;
    n = sig_len_m;
    if (n == 0) n = 1;
    if (n > SIG_BYTES) n = SIG_BYTES;
    return n;
  endfunction

  function automatic logic [7:0] sig_at(int unsigned k);
    logic [127:0] both;
    both = {sig_hi_m, sig_lo_m};
    return both[8*k +: 8];
  endfunction

  // Shift one byte into the window and work out the outcome it causes
  task automatic scan_byte(input in_item_t it);
    int unsigned n;
    int unsigned at;
    logic        hit;
    out_item_t   r;
    n = sig_span();
    if (it.first_byte) begin
      buf_pos = '0;
      hit_seen = 1'b0;
    end
    for (int i = SIG_BYTES - 1; i > 0; i--) win_q[i] = win_q[i-1];
    win_q[0] = it.data_byte;
    at = buf_pos;
    if (buf_pos != POS_MAX) buf_pos = buf_pos + 1'b1;
    hit = 1'b1;
    for (int k = 0; k < n; k++) begin
      if (sig_at(k) != WILDCARD_BYTE && sig_at(k) != win_q[n-1-k]) hit = 1'b0;
    end
    if (!hit_seen && at != POS_MAX && at + 1 >= n && hit) begin
      hit_seen = 1'b1;
      r.found = 1'b1;
      r.match_offset = OFFSET_W'(at + 1 - n);
      search_outcomes_q.push_back(r);
    end else if (it.last_byte && !hit_seen) begin
      r = '0;
      search_outcomes_q.push_back(r);
    end
    if (it.last_byte) begin
      buf_pos = '0;
      hit_seen = 1'b0;
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  // Driver: present queued bytes, honoring each item's drawn gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      byte_held = 1'b0;
      idle_cycles = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        scan_byte(in_item_i);
        bytes_sent++;
        byte_held = 1'b0;
      end
      if (!byte_held) begin
        if (byte_feed_q.size() != 0 && idle_cycles >= byte_feed_q[0].gap) begin
          feed_next = byte_feed_q.pop_front();
          in_item_i <= feed_next.item;
          in_valid_i <= 1'b1;
          byte_held = 1'b1;
          idle_cycles = 0;
        end else begin
          in_valid_i <= 1'b0;
          idle_cycles++;
        end
      end
    end
  end

  // Monitor: check each outcome, then draw the stall for the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        outcomes_seen++;
        if (search_outcomes_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected outcome, expected none, got found=%0b offset=%0h",
                   $time, out_item_o.found, out_item_o.match_offset);
        end else begin
          if (out_item_o.found !== search_outcomes_q[0].found)
            flag_mismatch("found", 32'(search_outcomes_q[0].found),
                          32'(out_item_o.found));
          if (out_item_o.match_offset !== search_outcomes_q[0].match_offset)
            flag_mismatch("match_offset", 32'(search_outcomes_q[0].match_offset),
                          32'(out_item_o.match_offset));
          void'(search_outcomes_q.pop_front());
        end
        if ($urandom_range(0, 15) == 0) rx_quiet = ~rx_quiet;
        hold_left = rx_quiet ? 0 : $urandom_range(0, 6);
      end else if (out_valid_o && hold_left > 0) begin
        hold_left--;
      end
      out_stall_i <= (hold_left > 0);
    end
  end

  // Queue one byte item
  task automatic send(input logic [7:0] d, input bit f, input bit l);
    feed_t e;
    e.item.data_byte = d;
    e.item.first_byte = f;
    e.item.last_byte = l;
    e.gap = tx_quiet ? 0 : $urandom_range(0, 6);
    byte_feed_q.push_back(e);
  endtask

  // Wait until every byte is taken and every outcome has come, then let
  // the pipeline settle for bytes that cause no outcome
  task automatic drain();
    do @(posedge clk_i);
    while (byte_feed_q.size() != 0 || byte_held || search_outcomes_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i);
    while (cfg_ready_o !== 1'b1);
    case (idx)
      REG_SIG_LOW:  sig_lo_m = val;
      REG_SIG_HIGH: sig_hi_m = val;
      default:      sig_len_m = val[LEN_W-1:0];
    endcase
  endtask

  task automatic load_signature(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [63:0] len);
    write_reg(REG_SIG_LOW, lo);
    write_reg(REG_SIG_HIGH, hi);
    write_reg(REG_SIG_LEN, len);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Signature word with roughly one byte in four a wildcard
  function automatic logic [63:0] sig_word();
    logic [63:0] w;
    for (int b = 0; b < 8; b++)
      w[8*b +: 8] = ($urandom_range(0, 3) == 0) ? WILDCARD_BYTE : 8'($urandom_range(0, 255));
    return w;
  endfunction

  // One framed buffer; most carry the signature, some with one bit broken
  task automatic queue_buffer(input int unsigned blen);
    logic [7:0]  bytes[$];
    int unsigned n;
    int unsigned s;
    n = sig_span();
    for (int i = 0; i < blen; i++)
      bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                           : sig_at($urandom_range(0, n - 1)));
    if (blen >= n && $urandom_range(0, 4) != 0) begin
      s = $urandom_range(0, blen - n);
      for (int k = 0; k < n; k++)
        if (sig_at(k) != WILDCARD_BYTE) bytes[s+k] = sig_at(k);
      if ($urandom_range(0, 4) == 0)
        bytes[s + $urandom_range(0, n - 1)] ^= 8'h01 << $urandom_range(0, 7);
    end
    for (int i = 0; i < blen; i++) send(bytes[i], i == 0, i == blen - 1);
  endtask

  // Stimulus and end of run
  initial begin
    int          left;
    int unsigned blen;
    int unsigned k;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] len;
    for (int i = 0; i < SIG_BYTES; i++) win_q[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset signature: one byte of zero
    send(8'h00, 1'b1, 1'b1);
    send(8'hFF, 1'b1, 1'b1);
    drain();

    // DE AD <any> EF
    load_signature(64'h0000_0000_EFCC_ADDE, 64'hFFFF_FFFF_FFFF_FFFF, 64'd4);
    // buffer shorter than the signature
    send(8'hDE, 1'b1, 1'b0); send(8'hAD, 1'b0, 1'b0); send(8'h00, 1'b0, 1'b1);
    // match ending on the final byte, wildcard over 55
    send(8'h11, 1'b1, 1'b0); send(8'h22, 1'b0, 1'b0); send(8'hDE, 1'b0, 1'b0);
    send(8'hAD, 1'b0, 1'b0); send(8'h55, 1'b0, 1'b0); send(8'hEF, 1'b0, 1'b1);
    // early match, rest of the buffer ignored
    send(8'hDE, 1'b1, 1'b0); send(8'hAD, 1'b0, 1'b0); send(8'h00, 1'b0, 1'b0);
    send(8'hEF, 1'b0, 1'b0); send(8'h77, 1'b0, 1'b0); send(8'hFF, 1'b0, 1'b1);
    // one-byte buffer
    send(8'h42, 1'b1, 1'b1);
    // buffer that starts without a first mark
    send(8'h00, 1'b0, 1'b0); send(8'hFF, 1'b0, 1'b1);
    // first mark in mid-buffer restarts the count
    send(8'hAA, 1'b1, 1'b0); send(8'hDE, 1'b1, 1'b0); send(8'hAD, 1'b0, 1'b0);
    send(8'hCC, 1'b0, 1'b0); send(8'hEF, 1'b0, 1'b1);
    drain();

    // Random phases, each under a fresh signature setting
    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        0: begin lo = '1; hi = '1; len = 64'd16; end
        1: begin lo = '0; hi = '0; len = 64'd1; end
        2: begin lo = sig_word(); hi = sig_word(); len = 64'd0; end
        3: begin lo = sig_word(); hi = sig_word(); len = 64'd17; end
        4: begin lo = sig_word(); hi = sig_word(); len = 64'd31; end
        5: begin lo = '1; hi = '0; len = 64'd16; end
        default: begin
          lo = sig_word();
          hi = sig_word();
          len = 64'($urandom_range(1, 16));
        end
      endcase
      // junk above the length field on some settings
      if (ph % 2 == 1) len = ({$urandom(), $urandom()} & ~64'h1F) | 64'(len[4:0]);
      load_signature(lo, hi, len);
      left = 140;
      while (left > 0) begin
        if ($urandom_range(0, 9) == 0) tx_quiet = ~tx_quiet;
        if ($urandom_range(0, 9) < 2) begin
          // unframed noise
          k = $urandom_range(1, 6);
          for (int i = 0; i < k; i++)
            send(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                 $urandom_range(0, 3) == 0);
          left -= k;
        end else begin
          blen = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                             : $urandom_range(1, sig_span() + 8);
          queue_buffer(blen);
          left -= blen;
        end
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (search_outcomes_q.size() != 0) begin
      fail_count++;
      $display("%0t: %0d outcomes never arrived", $time, search_outcomes_q.size());
    end
    $display("summary: %0d bytes, %0d outcomes checked, %0d signature settings",
             bytes_sent, outcomes_seen, settings_used);
    $display("summary: wildcards, lengths 0 to 31, framing noise, random stalls");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
